// ===== hw/rtl/fth_pkg.sv =====
// Package for the flow tuple hash unit: FNV-1a constants, the stage record
// handed between hash cells, and the functions that unpack a request into bytes.
// No dependencies.
package fth_pkg;

    localparam int unsigned NUM_BYTES  = 37;
    localparam int unsigned IDX_W      = $clog2(NUM_BYTES);
    localparam int unsigned TDATA_W    = NUM_BYTES * 8;
    localparam int unsigned HASH_W     = 32;

    localparam logic [HASH_W-1:0] OFFSET_BASIS = 32'd2166136261;

    localparam logic [1:0] ADDR_UNKNOWN = 2'd0;
    localparam logic [1:0] ADDR_IPV4    = 2'd1;
    localparam logic [1:0] ADDR_IPV6    = 2'd2;

    // Byte slots of the hash sequence; a disabled slot leaves the hash as is.
    localparam int unsigned SLOT_PROTO     = 0;
    localparam int unsigned SLOT_REMOTE_HI = 1;
    localparam int unsigned SLOT_REMOTE_LO = 9;
    localparam int unsigned SLOT_LOCAL_HI  = 17;
    localparam int unsigned SLOT_LOCAL_LO  = 25;
    localparam int unsigned SLOT_PORTS     = 33;

    typedef logic [TDATA_W-1:0]   byte_vec_t;
    typedef logic [NUM_BYTES-1:0] byte_en_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        byte_vec_t         bytes;
        byte_en_t          en;
    } stage_t;

    // XOR in one byte, then multiply by 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1.
    function automatic logic [HASH_W-1:0] fnv_mix(
        input logic [HASH_W-1:0] h,
        input logic [7:0]        b
    );
        logic [HASH_W-1:0] x;
        begin
            x = h ^ {24'd0, b};
            return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
        end
    endfunction

    // Reorder the request payload into hash order, addresses most significant byte first.
    function automatic byte_vec_t build_bytes(input logic [TDATA_W-1:0] d);
        byte_vec_t v;
        begin
            v = '0;
            v[SLOT_PROTO*8 +: 8] = d[7:0];
            for (int i = 0; i < 8; i++)
            begin
                v[(SLOT_REMOTE_HI + i)*8 +: 8] = d[8   + (7 - i)*8 +: 8];
                v[(SLOT_REMOTE_LO + i)*8 +: 8] = d[72  + (7 - i)*8 +: 8];
                v[(SLOT_LOCAL_HI  + i)*8 +: 8] = d[136 + (7 - i)*8 +: 8];
                v[(SLOT_LOCAL_LO  + i)*8 +: 8] = d[200 + (7 - i)*8 +: 8];
            end
            v[SLOT_PORTS*8 +: 32] = d[295:264];
            return v;
        end
    endfunction

    function automatic byte_en_t build_en(input logic [1:0] addr_type);
        byte_en_t e;
        logic     v4_or_v6;
        logic     v6;
        begin
            v4_or_v6 = (addr_type == ADDR_IPV4) || (addr_type == ADDR_IPV6);
            v6       = (addr_type == ADDR_IPV6);
            e = '0;
            e[SLOT_PROTO] = 1'b1;
            for (int i = 0; i < 8; i++)
            begin
                e[SLOT_REMOTE_HI + i] = (i < 4) ? v4_or_v6 : v6;
                e[SLOT_LOCAL_HI  + i] = (i < 4) ? v4_or_v6 : v6;
                e[SLOT_REMOTE_LO + i] = v6;
                e[SLOT_LOCAL_LO  + i] = v6;
            end
            for (int i = 0; i < 4; i++)
            begin
                e[SLOT_PORTS + i] = 1'b1;
            end
            return e;
        end
    endfunction

endpackage

// ===== hw/rtl/fth_cell.sv =====
// One hash cell: mixes its own byte slot into the running hash and hands the
// record to the next cell. Depends on fth_pkg.
module fth_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fth_pkg::stage_t in_stage,
    output logic            out_valid,
    input  logic            out_ready,
    output fth_pkg::stage_t out_stage
);

    localparam logic [fth_pkg::IDX_W-1:0] SLOT = fth_pkg::IDX_W'(CELL_IDX);

    logic            valid_reg;
    logic            valid_next;
    fth_pkg::stage_t stage_reg;
    fth_pkg::stage_t stage_next;
    logic            load;

    // Take a new request whenever this cell is empty or its result moves on.
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        stage_next = in_stage;
        if (in_stage.en[SLOT])
        begin
            stage_next.hash = fth_pkg::fnv_mix(in_stage.hash, in_stage.bytes[SLOT*8 +: 8]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== hw/rtl/flow_tuple_hash_unit.sv =====
// Top level of the flow tuple hash unit: a row of hash cells, one per byte slot.
// Depends on fth_pkg and fth_cell.
//
//   channel | dir | tdata                                   | tuser
//   s_axis  | in  | flow tuple, 296 bits                    | addr_type
//   m_axis  | out | tuple_hash, 32 bits                     | -
//
// Each request passes 37 cells, one per byte slot, and each cell registers the running
// hash; a new request is taken every cycle while m_axis_tready is high.
// Reset clears the valid bit of every cell; payload registers are not reset.
// A stall at m_axis backs up cell by cell: an empty cell still takes a request,
// so s_axis_tready drops only when every cell holds a request.
module flow_tuple_hash_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] protocol, [71:8] remote_addr_hi, [135:72] remote_addr_lo,
    // [199:136] local_addr_hi, [263:200] local_addr_lo,
    // [279:264] remote_port, [295:280] local_port
    input  logic [295:0] s_axis_tdata,
    // [1:0] addr_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] tuple_hash
    output logic [31:0]  m_axis_tdata
);

    localparam int unsigned N = fth_pkg::NUM_BYTES;

    fth_pkg::stage_t link_stage [N+1];
    logic            link_valid [N+1];
    logic            link_ready [N+1];

    assign link_stage[0].hash  = fth_pkg::OFFSET_BASIS;
    assign link_stage[0].bytes = fth_pkg::build_bytes(s_axis_tdata);
    assign link_stage[0].en    = fth_pkg::build_en(s_axis_tuser);
    assign link_valid[0]       = s_axis_tvalid;
    assign s_axis_tready       = link_ready[0];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fth_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_stage  (link_stage[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_stage (link_stage[i+1])
        );
    end

    assign link_ready[N]  = m_axis_tready;
    assign m_axis_tvalid  = link_valid[N];
    assign m_axis_tdata   = link_stage[N].hash;

endmodule
